/* sv/ddap_pkg.sv */
// shared widths, register codes and sideband types for the division distortion core
package ddap_pkg;

  localparam int CoordW        = 32;
  localparam int CoefW         = 64;
  localparam int DiffW         = CoordW + 1;
  localparam int SqW           = 2 * DiffW;
  localparam int SumW          = SqW;
  localparam int RootW         = 34;
  localparam int TrialW        = SumW + 2;
  localparam int ProdW         = RootW + CoefW;
  localparam int HornerShift   = 16;
  localparam int QuotW         = 40;
  localparam int RemW          = CoefW + 1;
  localparam int DivShift      = 58 - QuotW;
  localparam int FinW          = QuotW + 2;
  localparam int NumCoef       = 6;
  localparam int DefaultDegree = 5;
  localparam int CfgIdxW       = 4;

  localparam logic [CoefW-1:0]  CoefOne   = 64'h0400_0000_0000_0000;
  localparam logic [RemW-1:0]   MagPosMax = 65'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [RemW-1:0]   MagNegMax = 65'h0_8000_0000_0000_0000;
  localparam logic [CoordW-1:0] CoordMax  = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] CoordMin  = 32'h8000_0000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 4'd0,
    REG_CENTER_Y = 4'd1,
    REG_COEF_0   = 4'd2,
    REG_COEF_1   = 4'd3,
    REG_COEF_2   = 4'd4,
    REG_COEF_3   = 4'd5,
    REG_COEF_4   = 4'd6,
    REG_COEF_5   = 4'd7
  } cfg_reg_e;

  // point offsets as sign and magnitude, carried through the root stages
  typedef struct packed {
    logic             sx;
    logic [DiffW-1:0] ax;
    logic             sy;
    logic [DiffW-1:0] ay;
  } pt_side_t;

  // flags carried through the divider
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic zero;
    logic bad;
  } div_side_t;

  // sign-magnitude accumulator with saturation flag
  typedef struct packed {
    logic             n;
    logic [CoefW-1:0] m;
    logic             sat;
  } acc_t;

endpackage

/* sv/ddap_sqrt_pipe.sv */
// pipelined floor square root, one result bit per stage
module ddap_sqrt_pipe (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [ddap_pkg::SumW-1:0] sum_i,
  input  ddap_pkg::pt_side_t       side_i,
  output logic                     valid_o,
  output logic [ddap_pkg::RootW-1:0] root_o,
  output ddap_pkg::pt_side_t       side_o
);
  import ddap_pkg::*;

  logic [TrialW-1:0] rem_s  [RootW+1];
  logic [RootW-1:0]  res_s  [RootW+1];
  pt_side_t          side_s [RootW+1];
  logic              vld_s  [RootW+1];

  assign rem_s[0]  = TrialW'(sum_i);
  assign res_s[0]  = '0;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;

  // stage k settles root bit RootW-1-k
  for (genvar k = 0; k < RootW; k++) begin : g_bit
    localparam int B = RootW - 1 - k;
    logic [TrialW-1:0] trial;
    logic              take;
    logic [TrialW-1:0] rem_q;
    logic [RootW-1:0]  res_q;
    pt_side_t          side_q;
    logic              vld_q;

    assign trial = (TrialW'(res_s[k]) << (B + 1)) | (TrialW'(1) << (2 * B));
    assign take  = trial <= rem_s[k];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= take ? rem_s[k] - trial : rem_s[k];
        res_q  <= take ? (res_s[k] | (RootW'(1) << B)) : res_s[k];
        side_q <= side_s[k];
      end
    end

    assign rem_s[k+1]  = rem_q;
    assign res_s[k+1]  = res_q;
    assign side_s[k+1] = side_q;
    assign vld_s[k+1]  = vld_q;
  end

  assign valid_o = vld_s[RootW];
  assign root_o  = res_s[RootW];
  assign side_o  = side_s[RootW];

  // remainder left over is below 2*root+1, so the root is the floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rem_s[RootW] <= (TrialW'(root_o) << 1)))
    else $error("square root remainder too large");

endmodule

/* sv/ddap_div_pipe.sv */
// pipelined restoring divider for both axes, one quotient bit per stage
module ddap_div_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [ddap_pkg::RemW-1:0]  num_x_i,
  input  logic [ddap_pkg::RemW-1:0]  num_y_i,
  input  logic [ddap_pkg::CoefW-1:0] den_i,
  input  ddap_pkg::div_side_t       side_i,
  output logic                      valid_o,
  output logic [ddap_pkg::QuotW-1:0] q_x_o,
  output logic [ddap_pkg::QuotW-1:0] q_y_o,
  output ddap_pkg::div_side_t       side_o
);
  import ddap_pkg::*;

  logic [RemW-1:0]  rx_s   [QuotW+1];
  logic [RemW-1:0]  ry_s   [QuotW+1];
  logic [QuotW-1:0] qx_s   [QuotW+1];
  logic [QuotW-1:0] qy_s   [QuotW+1];
  logic [CoefW-1:0] den_s  [QuotW+1];
  div_side_t        side_s [QuotW+1];
  logic             vld_s  [QuotW+1];

  assign rx_s[0]   = num_x_i;
  assign ry_s[0]   = num_y_i;
  assign qx_s[0]   = '0;
  assign qy_s[0]   = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;

  // one shift, compare and subtract per stage
  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [RemW-1:0]  sh_x, sh_y, dext;
    logic             ge_x, ge_y;
    logic [RemW-1:0]  rx_q, ry_q;
    logic [QuotW-1:0] qx_q, qy_q;
    logic [CoefW-1:0] den_q;
    div_side_t        side_q;
    logic             vld_q;

    assign dext = {1'b0, den_s[k]};
    assign sh_x = {rx_s[k][RemW-2:0], 1'b0};
    assign sh_y = {ry_s[k][RemW-2:0], 1'b0};
    assign ge_x = sh_x >= dext;
    assign ge_y = sh_y >= dext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q   <= ge_x ? sh_x - dext : sh_x;
        ry_q   <= ge_y ? sh_y - dext : sh_y;
        qx_q   <= {qx_s[k][QuotW-2:0], ge_x};
        qy_q   <= {qy_s[k][QuotW-2:0], ge_y};
        den_q  <= den_s[k];
        side_q <= side_s[k];
      end
    end

    assign rx_s[k+1]   = rx_q;
    assign ry_s[k+1]   = ry_q;
    assign qx_s[k+1]   = qx_q;
    assign qy_s[k+1]   = qy_q;
    assign den_s[k+1]  = den_q;
    assign side_s[k+1] = side_q;
    assign vld_s[k+1]  = vld_q;
  end

  assign valid_o = vld_s[QuotW];
  assign q_x_o   = qx_s[QuotW];
  assign q_y_o   = qy_s[QuotW];
  assign side_o  = side_s[QuotW];

  // a quotient that fits leaves a remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !side_o.zero && !side_o.ovf_x) |-> (rx_s[QuotW] < RemW'(den_s[QuotW])))
    else $error("x remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !side_o.zero && !side_o.ovf_y) |-> (ry_s[QuotW] < RemW'(den_s[QuotW])))
    else $error("y remainder not below divisor");

endmodule

/* sv/division_distortion_apply_core.sv */
// top level of the division model lens distortion correction core
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready    tdata: in_x, in_y
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata: out_x, out_y; tuser: bad_result
//  cfg       in   cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// one word enters per cycle while the output is not held; the delay through the core is set
// mostly by the 34 root stages and the 40 quotient stages.
// reset clears all valid bits and loads center zero, coef_0 one, other coefficients zero.
// the whole pipeline holds while the output word waits; nothing is dropped or repeated.
// the configuration port is always ready.
module division_distortion_apply_core #(
  parameter int DEGREE = ddap_pkg::DefaultDegree
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*ddap_pkg::CoordW-1:0] s_axis_tdata,   // in_x, in_y
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*ddap_pkg::CoordW-1:0] m_axis_tdata,   // out_x, out_y
  output logic                          m_axis_tuser,   // bad_result
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ddap_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ddap_pkg::CoefW-1:0]    cfg_data_i
);
  import ddap_pkg::*;

  // sign-magnitude add with saturation to the signed 64-bit range
  function automatic acc_t add_sm(logic an, logic [CoefW-1:0] am,
                                  logic bn, logic [CoefW-1:0] bm);
    logic [RemW-1:0] mag;
    logic [RemW-1:0] lim;
    logic            n;
    acc_t            res;
    if (an == bn) begin
      mag = {1'b0, am} + {1'b0, bm};
      n   = an;
    end else if (am >= bm) begin
      mag = {1'b0, am - bm};
      n   = an;
    end else begin
      mag = {1'b0, bm - am};
      n   = bn;
    end
    if (mag == '0) n = 1'b0;
    lim     = n ? MagNegMax : MagPosMax;
    res.n   = n;
    res.sat = mag > lim;
    res.m   = res.sat ? lim[CoefW-1:0] : mag[CoefW-1:0];
    return res;
  endfunction

  // center plus signed quotient, saturated; flag in the top bit
  function automatic logic [CoordW:0] fin_axis(logic [CoordW-1:0] c,
                                               logic [QuotW-1:0] q,
                                               logic neg, logic ovf);
    logic [FinW-1:0] cext;
    logic [FinW-1:0] qext;
    logic [FinW-1:0] v;
    logic            hi, lo;
    cext = {{(FinW-CoordW){c[CoordW-1]}}, c};
    qext = FinW'(q);
    v    = cext + (neg ? (~qext + FinW'(1)) : qext);
    hi   = !v[FinW-1] && (v[FinW-2:CoordW-1] != '0);
    lo   = v[FinW-1] && (v[FinW-2:CoordW-1] != '1);
    if (ovf)     return {1'b1, neg ? CoordMin : CoordMax};
    else if (hi) return {1'b1, CoordMax};
    else if (lo) return {1'b1, CoordMin};
    else         return {1'b0, v[CoordW-1:0]};
  endfunction

  logic en;
  logic out_vld_q;

  // configuration registers, coefficients kept as sign and magnitude
  logic [CoordW-1:0] center_x_q, center_y_q;
  logic              coef_n_q [NumCoef];
  logic [CoefW-1:0]  coef_m_q [NumCoef];
  logic [CoefW-1:0]  cfg_mag;

  assign cfg_ready_o = 1'b1;
  assign cfg_mag = cfg_data_i[CoefW-1] ? (~cfg_data_i + CoefW'(1)) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      for (int i = 0; i < NumCoef; i++) begin
        coef_n_q[i] <= 1'b0;
        coef_m_q[i] <= (i == 0) ? CoefOne : '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_X: center_x_q <= cfg_data_i[CoordW-1:0];
        REG_CENTER_Y: center_y_q <= cfg_data_i[CoordW-1:0];
        REG_COEF_0: begin coef_n_q[0] <= cfg_data_i[CoefW-1]; coef_m_q[0] <= cfg_mag; end
        REG_COEF_1: begin coef_n_q[1] <= cfg_data_i[CoefW-1]; coef_m_q[1] <= cfg_mag; end
        REG_COEF_2: begin coef_n_q[2] <= cfg_data_i[CoefW-1]; coef_m_q[2] <= cfg_mag; end
        REG_COEF_3: begin coef_n_q[3] <= cfg_data_i[CoefW-1]; coef_m_q[3] <= cfg_mag; end
        REG_COEF_4: begin coef_n_q[4] <= cfg_data_i[CoefW-1]; coef_m_q[4] <= cfg_mag; end
        REG_COEF_5: begin coef_n_q[5] <= cfg_data_i[CoefW-1]; coef_m_q[5] <= cfg_mag; end
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being emptied
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // front stages: offsets, magnitudes, squares, sum
  logic [DiffW-1:0] dx_q, dy_q;
  pt_side_t         ab_q, sq_side_q, sum_side_q;
  logic [SqW-1:0]   sqx_q, sqy_q;
  logic [SumW-1:0]  sum_q;
  logic             v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= {s_axis_tdata[CoordW-1], s_axis_tdata[CoordW-1:0]}
            - {center_x_q[CoordW-1], center_x_q};
      dy_q <= {s_axis_tdata[2*CoordW-1], s_axis_tdata[2*CoordW-1:CoordW]}
            - {center_y_q[CoordW-1], center_y_q};
      ab_q.sx <= dx_q[DiffW-1];
      ab_q.ax <= dx_q[DiffW-1] ? (~dx_q + DiffW'(1)) : dx_q;
      ab_q.sy <= dy_q[DiffW-1];
      ab_q.ay <= dy_q[DiffW-1] ? (~dy_q + DiffW'(1)) : dy_q;
      sqx_q     <= SqW'(ab_q.ax) * SqW'(ab_q.ax);
      sqy_q     <= SqW'(ab_q.ay) * SqW'(ab_q.ay);
      sq_side_q <= ab_q;
      sum_q      <= SumW'(sqx_q) + SumW'(sqy_q);
      sum_side_q <= sq_side_q;
    end
  end

  // radius
  logic              rt_vld;
  logic [RootW-1:0]  rt_root;
  pt_side_t          rt_side;

  ddap_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .sum_i   (sum_q),
    .side_i  (sum_side_q),
    .valid_o (rt_vld),
    .root_o  (rt_root),
    .side_o  (rt_side)
  );

  // horner chain, three stages per coefficient
  logic             h_vld  [DEGREE+2];
  logic             h_accn [DEGREE+2];
  logic [CoefW-1:0] h_accm [DEGREE+2];
  logic             h_bad  [DEGREE+2];
  logic [RootW-1:0] h_r    [DEGREE+2];
  pt_side_t         h_side [DEGREE+2];

  assign h_vld[0]  = rt_vld;
  assign h_accn[0] = 1'b0;
  assign h_accm[0] = '0;
  assign h_bad[0]  = 1'b0;
  assign h_r[0]    = rt_root;
  assign h_side[0] = rt_side;

  for (genvar s = 0; s <= DEGREE; s++) begin : g_horner
    localparam int J = DEGREE - s;
    localparam int HiLsb = CoefW + HornerShift;
    // partial products
    logic [RootW+31:0] m_plo_q, m_phi_q;
    logic              m_vld_q, m_accn_q, m_bad_q;
    logic [RootW-1:0]  m_r_q;
    pt_side_t          m_side_q;
    // product scaled down by 2^16
    logic [ProdW-1:0]  prod;
    logic [CoefW-1:0]  c_tlo_q;
    logic              c_thi_q, c_tn_q, c_vld_q, c_bad_q;
    logic [RootW-1:0]  c_r_q;
    pt_side_t          c_side_q;
    // coefficient added
    acc_t              sum_d;
    logic              a_vld_q, a_accn_q, a_bad_q;
    logic [CoefW-1:0]  a_accm_q;
    logic [RootW-1:0]  a_r_q;
    pt_side_t          a_side_q;

    assign prod  = {m_phi_q, 32'b0} + ProdW'(m_plo_q);
    assign sum_d = add_sm(c_tn_q, c_tlo_q, coef_n_q[J], coef_m_q[J]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m_vld_q <= 1'b0;
        c_vld_q <= 1'b0;
        a_vld_q <= 1'b0;
      end else if (en) begin
        m_vld_q <= h_vld[s];
        c_vld_q <= m_vld_q;
        a_vld_q <= c_vld_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        m_plo_q  <= (RootW+32)'(h_r[s]) * (RootW+32)'(h_accm[s][31:0]);
        m_phi_q  <= (RootW+32)'(h_r[s]) * (RootW+32)'(h_accm[s][CoefW-1:32]);
        m_accn_q <= h_accn[s];
        m_bad_q  <= h_bad[s];
        m_r_q    <= h_r[s];
        m_side_q <= h_side[s];

        c_tlo_q  <= prod[HiLsb-1:HornerShift];
        c_thi_q  <= |prod[ProdW-1:HiLsb];
        c_tn_q   <= ((prod[HiLsb-1:HornerShift] != '0) || (|prod[ProdW-1:HiLsb]))
                    ? m_accn_q : 1'b0;
        c_bad_q  <= m_bad_q;
        c_r_q    <= m_r_q;
        c_side_q <= m_side_q;

        if (c_thi_q) begin
          a_accn_q <= c_tn_q;
          a_accm_q <= c_tn_q ? MagNegMax[CoefW-1:0] : MagPosMax[CoefW-1:0];
          a_bad_q  <= 1'b1;
        end else begin
          a_accn_q <= sum_d.n;
          a_accm_q <= sum_d.m;
          a_bad_q  <= c_bad_q | sum_d.sat;
        end
        a_r_q    <= c_r_q;
        a_side_q <= c_side_q;
      end
    end

    assign h_vld[s+1]  = a_vld_q;
    assign h_accn[s+1] = a_accn_q;
    assign h_accm[s+1] = a_accm_q;
    assign h_bad[s+1]  = a_bad_q;
    assign h_r[s+1]    = a_r_q;
    assign h_side[s+1] = a_side_q;
  end

  // divider setup: scaled numerators, overflow and zero checks
  logic             p_vld_q;
  logic [RemW-1:0]  p_num_x_q, p_num_y_q;
  logic [CoefW-1:0] p_den_q;
  div_side_t        p_side_q;
  pt_side_t         hs;

  assign hs = h_side[DEGREE+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= h_vld[DEGREE+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_num_x_q      <= RemW'(hs.ax) << DivShift;
      p_num_y_q      <= RemW'(hs.ay) << DivShift;
      p_den_q        <= h_accm[DEGREE+1];
      p_side_q.neg_x <= hs.sx ^ h_accn[DEGREE+1];
      p_side_q.neg_y <= hs.sy ^ h_accn[DEGREE+1];
      p_side_q.ovf_x <= (CoefW'(hs.ax) << DivShift) >= h_accm[DEGREE+1];
      p_side_q.ovf_y <= (CoefW'(hs.ay) << DivShift) >= h_accm[DEGREE+1];
      p_side_q.zero  <= h_accm[DEGREE+1] == '0;
      p_side_q.bad   <= h_bad[DEGREE+1];
    end
  end

  logic             dv_vld;
  logic [QuotW-1:0] dv_qx, dv_qy;
  div_side_t        dv_side;

  ddap_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_vld_q),
    .num_x_i (p_num_x_q),
    .num_y_i (p_num_y_q),
    .den_i   (p_den_q),
    .side_i  (p_side_q),
    .valid_o (dv_vld),
    .q_x_o   (dv_qx),
    .q_y_o   (dv_qy),
    .side_o  (dv_side)
  );

  // output word: add center, saturate, flag
  logic [CoordW:0]   fx, fy;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic              bad_q;

  assign fx = fin_axis(center_x_q, dv_qx, dv_side.neg_x, dv_side.ovf_x);
  assign fy = fin_axis(center_y_q, dv_qy, dv_side.neg_y, dv_side.ovf_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_side.zero) begin
        out_x_q <= center_x_q;
        out_y_q <= center_y_q;
        bad_q   <= 1'b1;
      end else begin
        out_x_q <= fx[CoordW-1:0];
        out_y_q <= fy[CoordW-1:0];
        bad_q   <= dv_side.bad | fx[CoordW] | fy[CoordW];
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = bad_q;

  // a zero denominator gives the center with the flag raised
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && dv_vld && dv_side.zero) |=>
      (m_axis_tuser && m_axis_tdata == {$past(center_y_q), $past(center_x_q)}))
    else $error("zero denominator did not return the flagged center");

endmodule
